@@ rtl/slcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants, glyph tables and mask helpers for the segment LCD formatter.
package slcd_pkg;

  localparam int IMG_BYTES = 18;
  localparam int IMG_BITS  = IMG_BYTES * 8;
  localparam int SEGS      = 13;
  localparam int VAL_W     = 16;
  localparam int N_W       = 11;
  localparam int LVL_W     = 7;
  localparam int SYM_W     = 3;

  // Reciprocal constants for division by ten and by one hundred.
  localparam int          RECIP10_SH  = 19;
  localparam logic [15:0] RECIP10     = 16'hCCCD;
  localparam int          PROD10_W    = 32;
  localparam int          NPROD10_W   = N_W + 16;
  localparam int          RECIP100_SH = 17;
  localparam logic [10:0] RECIP100    = 11'd1311;
  localparam int          NPROD100_W  = N_W + 11;

  // Number display limits, in tenths.
  localparam logic signed [VAL_W-1:0] TOP_HI_LIM = 16'sd19995;
  localparam logic signed [VAL_W-1:0] BOT_HI_LIM = 16'sd9995;
  localparam logic signed [VAL_W-1:0] LO_LIM     = -16'sd995;
  localparam logic signed [VAL_W-1:0] TOP_PT_LIM = 16'sd1995;
  localparam logic signed [VAL_W-1:0] BOT_PT_LIM = 16'sd995;
  localparam logic signed [VAL_W-1:0] PT_LO_LIM  = -16'sd95;
  localparam logic [3:0]              ROUND_LIM  = 4'd5;
  localparam logic [N_W-1:0]          LEAD_LIM   = 11'd999;
  localparam logic [N_W-1:0]          LEFT_LIM   = 11'd99;

  // Battery bar step thresholds, in percent.
  localparam logic [LVL_W-1:0] BATT_STEP1 = 7'd16;
  localparam logic [LVL_W-1:0] BATT_STEP2 = 7'd33;
  localparam logic [LVL_W-1:0] BATT_STEP3 = 7'd49;
  localparam logic [LVL_W-1:0] BATT_STEP4 = 7'd67;
  localparam logic [LVL_W-1:0] BATT_STEP5 = 7'd83;

  localparam int SYM_BYTE = 17;

  typedef logic [IMG_BITS-1:0]    img_t;
  typedef logic [0:SEGS-1][7:0]   pos_tab_t;

  typedef enum logic [2:0] {
    FN_TOP  = 3'd0,
    FN_BOT  = 3'd1,
    FN_SYM  = 3'd2,
    FN_BATT = 3'd3,
    FN_LINK = 3'd4
  } func_t;

  typedef struct packed {
    func_t                   func;
    logic signed [VAL_W-1:0] value;
    logic                    pct;
    logic [SYM_W-1:0]        sym;
    logic                    en;
    logic [LVL_W-1:0]        lvl;
  } item_t;

  typedef struct packed {
    func_t            func;
    logic             pct;
    logic [SYM_W-1:0] sym;
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic             hi;
    logic             lo;
    logic             point;
    logic             neg;
  } ctl_t;

  typedef struct packed {
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
    logic       show_l;
    logic       lead;
  } digits_t;

  typedef struct packed {
    img_t clr;
    img_t set;
  } paint_t;

  // Segment positions as image bit indexes (byte * 8 + bit), segment 1 first.
  localparam pos_tab_t POS_TOP_L = '{8'd19, 8'd47, 8'd31, 8'd30, 8'd29, 8'd28, 8'd17,
                                     8'd16, 8'd20, 8'd21, 8'd22, 8'd23, 8'd18};
  localparam pos_tab_t POS_TOP_M = '{8'd39, 8'd46, 8'd35, 8'd34, 8'd33, 8'd32, 8'd37,
                                     8'd36, 8'd24, 8'd25, 8'd26, 8'd27, 8'd38};
  localparam pos_tab_t POS_TOP_R = '{8'd6, 8'd139, 8'd138, 8'd137, 8'd136, 8'd45, 8'd4,
                                     8'd0, 8'd1, 8'd2, 8'd3, 8'd7, 8'd5};
  localparam pos_tab_t POS_BOT_L = '{8'd55, 8'd67, 8'd51, 8'd50, 8'd49, 8'd48, 8'd53,
                                     8'd52, 8'd40, 8'd41, 8'd42, 8'd43, 8'd54};
  localparam pos_tab_t POS_BOT_M = '{8'd59, 8'd66, 8'd71, 8'd70, 8'd69, 8'd68, 8'd57,
                                     8'd56, 8'd60, 8'd61, 8'd62, 8'd63, 8'd58};
  localparam pos_tab_t POS_BOT_R = '{8'd75, 8'd143, 8'd87, 8'd86, 8'd85, 8'd84, 8'd73,
                                     8'd72, 8'd76, 8'd77, 8'd78, 8'd79, 8'd74};

  function automatic img_t img_byte(input int b, input logic [7:0] v);
    img_t r;
    r = '0;
    r[b*8 +: 8] = v;
    return r;
  endfunction

  function automatic logic [SEGS-1:0] glyph(input logic [3:0] d);
    logic [SEGS-1:0] m;
    case (d)
      4'd0: m = 13'h0FFF;
      4'd1: m = 13'h003E;
      4'd2: m = 13'h1BEF;
      4'd3: m = 13'h1AFF;
      4'd4: m = 13'h1E3E;
      4'd5: m = 13'h1EFB;
      4'd6: m = 13'h1FFB;
      4'd7: m = 13'h083F;
      4'd8: m = 13'h1FFF;
      4'd9: m = 13'h1EFF;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Scatters the lit segments of one digit onto the image.
  function automatic img_t place(input logic [3:0] d, input pos_tab_t pos);
    logic [SEGS-1:0] m;
    img_t            r;
    m = glyph(d);
    r = '0;
    for (int s = 0; s < SEGS; s++) begin
      if (m[s]) r[pos[s]] = 1'b1;
    end
    return r;
  endfunction

  localparam img_t TOP_CLR    = img_byte(0, 8'hFF) | img_byte(1, 8'h01) | img_byte(2, 8'hFF) |
                                img_byte(3, 8'hFF) | img_byte(4, 8'hFF) | img_byte(5, 8'hF0) |
                                img_byte(17, 8'h0F);
  localparam img_t TOP_HI_SET = img_byte(2, 8'hF5) | img_byte(3, 8'h7B) | img_byte(4, 8'h10);
  localparam img_t TOP_LO_SET = img_byte(2, 8'hF3) | img_byte(3, 8'h13) | img_byte(4, 8'h77);
  localparam img_t TOP_POINT  = img_byte(5, 8'h10);
  localparam img_t TOP_NEG    = img_byte(2, 8'h04);
  localparam img_t TOP_LEAD   = img_byte(1, 8'h01);

  localparam img_t BOT_CLR    = img_byte(5, 8'h0F) | img_byte(6, 8'hFF) | img_byte(7, 8'hFF) |
                                img_byte(8, 8'hFF) | img_byte(9, 8'hFF) | img_byte(10, 8'hF0) |
                                img_byte(17, 8'h80);
  localparam img_t BOT_PCT    = img_byte(8, 8'h02);
  localparam img_t BOT_HI_SET = img_byte(5, 8'h0F) | img_byte(6, 8'h57) | img_byte(7, 8'hB1);
  localparam img_t BOT_LO_SET = img_byte(5, 8'h0F) | img_byte(6, 8'h31) | img_byte(7, 8'h37) |
                                img_byte(8, 8'h70);
  localparam img_t BOT_POINT  = img_byte(8, 8'h01);
  localparam img_t BOT_NEG    = img_byte(6, 8'h40);

  localparam img_t SYM_CLR    = img_byte(SYM_BYTE, 8'h70);
  localparam img_t BATT_CLR   = img_byte(1, 8'hEE);
  localparam img_t BATT_FRAME = img_byte(1, 8'h20);
  localparam img_t BATT_SEG1  = img_byte(1, 8'h02);
  localparam img_t BATT_SEG2  = img_byte(1, 8'h04);
  localparam img_t BATT_SEG3  = img_byte(1, 8'h08);
  localparam img_t BATT_SEG4  = img_byte(1, 8'h80);
  localparam img_t BATT_SEG5  = img_byte(1, 8'h40);
  localparam img_t LINK_ICON  = img_byte(1, 8'h10);

endpackage

@@ rtl/segment_lcd_number_formatter.sv @@
`timescale 1ns / 1ps
// Top level of the segment LCD formatter: input register, number pipeline, image register.
//
// The block keeps the 18-byte image of a segment LCD and rewrites one part of it for
// every transaction on the slave channel. s_tuser selects the part (top number, bottom
// number, unit symbol, battery bar or link icon) and s_tdata carries the operands.
// After each transaction the master channel delivers the whole updated image as one
// transaction, in the same order as the inputs.
// One transaction is accepted in every cycle while the output is not stalled; the
// number path is a pipeline of input register, two scaling stages, two digit stages
// and the image register, and each multiply by a reciprocal constant has a register
// after it.
// Reset clears the image to all zeros and empties the pipeline.
// When the receiver holds m_tready low, the image register keeps its result and the
// stages behind it keep filling; s_tready drops only once every stage holds an item.
module segment_lcd_number_formatter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // From bit 0: value_tenths[15:0], percent_on, symbol_code[2:0], enable,
  // battery_percent[6:0], four zero bits.
  input  logic [31:0]                   s_tdata,
  // func[2:0]
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // From bit 0: image_low[63:0], image_mid[63:0], image_high[15:0].
  output logic [slcd_pkg::IMG_BITS-1:0] m_tdata
);
  import slcd_pkg::*;

  // Input register.
  logic     in_valid;
  logic     in_ready;
  item_t    in_item;
  item_t    item_next;

  logic     sc_ready;
  logic     sc_valid;
  ctl_t     sc_ctl;
  logic [N_W-1:0] sc_n;

  logic     dg_ready;
  logic     dg_valid;
  ctl_t     dg_ctl;
  digits_t  dg_digits;

  paint_t   paint;
  logic     img_ready;
  img_t     image_next;

  assign in_ready = !in_valid || sc_ready;
  assign s_tready = in_ready;

  always_comb begin
    item_next.func  = func_t'(s_tuser);
    item_next.value = s_tdata[15:0];
    item_next.pct   = s_tdata[16];
    item_next.sym   = s_tdata[19:17];
    item_next.en    = s_tdata[20];
    item_next.lvl   = s_tdata[27:21];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) in_item <= item_next;
  end

  slcd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (sc_ready),
    .in_item   (in_item),
    .out_valid (sc_valid),
    .out_ready (dg_ready),
    .out_ctl   (sc_ctl),
    .out_n     (sc_n)
  );

  slcd_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sc_valid),
    .in_ready   (dg_ready),
    .in_ctl     (sc_ctl),
    .in_n       (sc_n),
    .out_valid  (dg_valid),
    .out_ready  (img_ready),
    .out_ctl    (dg_ctl),
    .out_digits (dg_digits)
  );

  slcd_paint u_paint (
    .ctl   (dg_ctl),
    .dg    (dg_digits),
    .paint (paint)
  );

  // The output register is the image itself: it changes only when a new result is
  // loaded, so it always holds the image as left by the latest transaction.
  assign img_ready  = !m_tvalid || m_tready;
  assign image_next = (m_tdata & ~paint.clr) | paint.set;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (img_ready) begin
      m_tvalid <= dg_valid;
      if (dg_valid) m_tdata <= image_next;
    end
  end

endmodule

@@ rtl/slcd_scale.sv @@
`timescale 1ns / 1ps
// Two-stage range check, magnitude and divide-by-ten rounding of the number value.
module slcd_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  slcd_pkg::item_t             in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output slcd_pkg::ctl_t              out_ctl,
  output logic [slcd_pkg::N_W-1:0]    out_n
);
  import slcd_pkg::*;

  logic                    a_valid;
  logic                    a_ready;
  logic                    b_ready;
  ctl_t                    a_ctl;
  logic [VAL_W-1:0]        a_mag;
  logic [PROD10_W-1:0]     a_prod;

  logic signed [VAL_W-1:0] v;
  logic                    top_sel;
  ctl_t                    ctl_next;
  logic [VAL_W-1:0]        mag_next;
  logic [PROD10_W-1:0]     prod_next;

  logic [PROD10_W-RECIP10_SH-1:0] q;
  logic [VAL_W-1:0]        q_times10;
  logic [VAL_W-1:0]        rem;
  logic [VAL_W-1:0]        rounded;
  logic [N_W-1:0]          n_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign v       = in_item.value;
  assign top_sel = (in_item.func == FN_TOP);

  always_comb begin
    ctl_next.func  = in_item.func;
    ctl_next.pct   = in_item.pct;
    ctl_next.sym   = in_item.sym;
    ctl_next.en    = in_item.en;
    ctl_next.lvl   = in_item.lvl;
    ctl_next.hi    = top_sel ? (v > TOP_HI_LIM) : (v > BOT_HI_LIM);
    ctl_next.lo    = (v < LO_LIM);
    ctl_next.point = !((top_sel ? (v > TOP_PT_LIM) : (v > BOT_PT_LIM)) || (v < PT_LO_LIM));
    ctl_next.neg   = v[VAL_W-1];
    mag_next       = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    prod_next      = PROD10_W'(mag_next) * PROD10_W'(RECIP10);
  end

  // Quotient by ten from the reciprocal product; the remainder decides rounding.
  always_comb begin
    q         = a_prod[PROD10_W-1:RECIP10_SH];
    q_times10 = VAL_W'({q, 3'b000}) + VAL_W'({q, 1'b0});
    rem       = a_mag - q_times10;
    rounded   = VAL_W'(q) + ((rem[3:0] > ROUND_LIM) ? VAL_W'(1) : VAL_W'(0));
    n_next    = a_ctl.point ? a_mag[N_W-1:0] : rounded[N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ctl  <= ctl_next;
      a_mag  <= mag_next;
      a_prod <= prod_next;
    end
    if (b_ready) begin
      out_ctl <= a_ctl;
      out_n   <= n_next;
    end
  end

endmodule

@@ rtl/slcd_digits.sv @@
`timescale 1ns / 1ps
// Two-stage split of the displayed magnitude into three decimal digits.
module slcd_digits (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  slcd_pkg::ctl_t              in_ctl,
  input  logic [slcd_pkg::N_W-1:0]    in_n,
  output logic                        out_valid,
  input  logic                        out_ready,
  output slcd_pkg::ctl_t              out_ctl,
  output slcd_pkg::digits_t           out_digits
);
  import slcd_pkg::*;

  logic                   a_valid;
  logic                   a_ready;
  logic                   b_ready;
  ctl_t                   a_ctl;
  logic [N_W-1:0]         a_n;
  logic [NPROD10_W-1:0]   a_prod10;
  logic [NPROD100_W-1:0]  a_prod100;

  logic [NPROD10_W-RECIP10_SH-1:0]   q10;
  logic [NPROD100_W-RECIP100_SH-1:0] q100;
  logic [N_W-1:0]         t10;
  logic [N_W-1:0]         r0;
  logic [7:0]             t100;
  logic [7:0]             r1;
  logic [NPROD100_W-RECIP100_SH-1:0] r2;
  digits_t                digits_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    q10  = a_prod10[NPROD10_W-1:RECIP10_SH];
    q100 = a_prod100[NPROD100_W-1:RECIP100_SH];
    t10  = N_W'({q10, 3'b000}) + N_W'({q10, 1'b0});
    r0   = a_n - t10;
    t100 = 8'({q100, 3'b000}) + 8'({q100, 1'b0});
    r1   = q10 - t100;
    // The hundreds count stays below thirty, so two compares give it modulo ten.
    if (q100 >= 5'd20)      r2 = q100 - 5'd20;
    else if (q100 >= 5'd10) r2 = q100 - 5'd10;
    else                    r2 = q100;
    digits_next.d0     = r0[3:0];
    digits_next.d1     = r1[3:0];
    digits_next.d2     = r2[3:0];
    digits_next.show_l = (a_n > LEFT_LIM);
    digits_next.lead   = (a_n > LEAD_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ctl     <= in_ctl;
      a_n       <= in_n;
      a_prod10  <= NPROD10_W'(in_n) * NPROD10_W'(RECIP10);
      a_prod100 <= NPROD100_W'(in_n) * NPROD100_W'(RECIP100);
    end
    if (b_ready) begin
      out_ctl    <= a_ctl;
      out_digits <= digits_next;
    end
  end

endmodule

@@ rtl/slcd_paint.sv @@
`timescale 1ns / 1ps
// Builds the clear and set masks that one transaction applies to the LCD image.
module slcd_paint (
  input  slcd_pkg::ctl_t    ctl,
  input  slcd_pkg::digits_t dg,
  output slcd_pkg::paint_t  paint
);
  import slcd_pkg::*;

  img_t clr;
  img_t set;

  always_comb begin
    clr = '0;
    set = '0;
    case (ctl.func)
      FN_TOP: begin
        clr = TOP_CLR;
        if (ctl.hi) begin
          set = TOP_HI_SET;
        end else if (ctl.lo) begin
          set = TOP_LO_SET;
        end else begin
          set = place(dg.d1, POS_TOP_M) | place(dg.d0, POS_TOP_R);
          if (dg.show_l) set = set | place(dg.d2, POS_TOP_L);
          if (ctl.point) set = set | TOP_POINT;
          if (ctl.neg) set = set | TOP_NEG;
          if (dg.lead) set = set | TOP_LEAD;
        end
      end
      FN_BOT: begin
        clr = BOT_CLR;
        if (ctl.pct) set = BOT_PCT;
        if (ctl.hi) begin
          set = set | BOT_HI_SET;
        end else if (ctl.lo) begin
          set = set | BOT_LO_SET;
        end else begin
          set = set | place(dg.d1, POS_BOT_M) | place(dg.d0, POS_BOT_R);
          if (dg.show_l) set = set | place(dg.d2, POS_BOT_L);
          if (ctl.point) set = set | BOT_POINT;
          if (ctl.neg) set = set | BOT_NEG;
        end
      end
      FN_SYM: begin
        // Degree, dash and underscore land on bits 6, 5 and 4.
        clr = SYM_CLR;
        set = img_byte(SYM_BYTE, {1'b0, ctl.sym[0], ctl.sym[1], ctl.sym[2], 4'b0000});
      end
      FN_BATT: begin
        clr = BATT_CLR;
        if (ctl.en) begin
          set = BATT_FRAME;
          if (ctl.lvl >= BATT_STEP1) set = set | BATT_SEG1;
          if (ctl.lvl >= BATT_STEP2) set = set | BATT_SEG2;
          if (ctl.lvl >= BATT_STEP3) set = set | BATT_SEG3;
          if (ctl.lvl >= BATT_STEP4) set = set | BATT_SEG4;
          if (ctl.lvl >= BATT_STEP5) set = set | BATT_SEG5;
        end
      end
      FN_LINK: begin
        clr = LINK_ICON;
        if (ctl.en) set = LINK_ICON;
      end
      default: begin
        clr = '0;
        set = '0;
      end
    endcase
  end

  assign paint.clr = clr;
  assign paint.set = set;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the segment LCD formatter with its own image predictor.
module testbench;
  import slcd_pkg::*;

  // Func codes beyond the defined set leave the image untouched.
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

  // Display limits in tenths, as the panel firmware defines them.
  localparam int TOP_HI_LIMIT    = 19995;
  localparam int BOT_HI_LIMIT    = 9995;
  localparam int LOW_LIMIT       = -995;
  localparam int TOP_POINT_LIMIT = 1995;
  localparam int BOT_POINT_LIMIT = 995;
  localparam int POINT_LOW_LIMIT = -95;

  // Digit positions on the glass, as row indexes into the segment bit table below.
  localparam int SLOT_TOP_L = 0;
  localparam int SLOT_TOP_M = 1;
  localparam int SLOT_TOP_R = 2;
  localparam int SLOT_BOT_L = 3;
  localparam int SLOT_BOT_M = 4;
  localparam int SLOT_BOT_R = 5;

  // Lit segments per decimal digit, segment 1 in bit 0.
  localparam logic [0:9][12:0] DIGIT_SEGS = '{
    13'h0FFF, 13'h003E, 13'h1BEF, 13'h1AFF, 13'h1E3E,
    13'h1EFB, 13'h1FFB, 13'h083F, 13'h1FFF, 13'h1EFF};

  // Image bit (byte * 8 + bit) that each segment of each digit position drives.
  localparam logic [0:5][0:12][7:0] SEG_BIT = '{
    '{8'd19, 8'd47, 8'd31, 8'd30, 8'd29, 8'd28, 8'd17, 8'd16, 8'd20, 8'd21, 8'd22, 8'd23, 8'd18},
    '{8'd39, 8'd46, 8'd35, 8'd34, 8'd33, 8'd32, 8'd37, 8'd36, 8'd24, 8'd25, 8'd26, 8'd27, 8'd38},
    '{8'd6, 8'd139, 8'd138, 8'd137, 8'd136, 8'd45, 8'd4, 8'd0, 8'd1, 8'd2, 8'd3, 8'd7, 8'd5},
    '{8'd55, 8'd67, 8'd51, 8'd50, 8'd49, 8'd48, 8'd53, 8'd52, 8'd40, 8'd41, 8'd42, 8'd43, 8'd54},
    '{8'd59, 8'd66, 8'd71, 8'd70, 8'd69, 8'd68, 8'd57, 8'd56, 8'd60, 8'd61, 8'd62, 8'd63, 8'd58},
    '{8'd75, 8'd143, 8'd87, 8'd86, 8'd85, 8'd84, 8'd73, 8'd72, 8'd76, 8'd77, 8'd78, 8'd79, 8'd74}};

  // One display update as the driver sends it, plus its pacing.
  typedef struct {
    logic [2:0]        func;
    logic signed [15:0] value;
    logic              pct;
    logic [2:0]        sym;
    logic              en;
    logic [6:0]        lvl;
    int                gap;    // idle cycles after this transaction
    bit                drain;  // wait for every outstanding image before sending
  } lcd_update_t;

  // The image split into the three words that are checked separately.
  typedef struct {
    logic [63:0] low;
    logic [63:0] mid;
    logic [15:0] high;
  } image_words_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic [2:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [IMG_BITS-1:0] m_tdata;

  segment_lcd_number_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predicted panel image, byte 0 in bits 7:0.
  logic [IMG_BITS-1:0] lcd_model = '0;

  lcd_update_t  pending_updates[$];
  image_words_t expected_images[$];
  lcd_update_t  on_bus;
  int           idle_left = 0;
  int           stall_left = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;
  int           total_updates = 0;
  int           updates_done = 0;
  int           images_checked = 0;
  int           mismatch_count = 0;
  int           func_hits[8];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h (image %0d)", what, got, want, images_checked);
    mismatch_count++;
  endtask

  // Magnitude shown on the glass: whole units with rounding once the value is too wide
  // to show with its decimal point. A remainder of exactly five rounds down.
  function automatic int unsigned shown_magnitude(input int v, input int point_limit,
                                                  output bit neg, output bit point);
    int unsigned mag;
    neg = (v < 0);
    mag = (v < 0) ? -v : v;
    if (v > point_limit || v < POINT_LOW_LIMIT) begin
      point = 1'b0;
      mag = mag / 10 + ((mag % 10 > 5) ? 1 : 0);
    end else begin
      point = 1'b1;
    end
    return mag;
  endfunction

  function automatic void light_digit(input int unsigned d, input int slot);
    logic [12:0] segs;
    int          s;
    segs = DIGIT_SEGS[d % 10];
    for (s = 0; s < 13; s++) begin
      if (segs[s]) lcd_model[SEG_BIT[slot][s]] = 1'b1;
    end
  endfunction

  // Applies one update to the predicted image and returns the image the block must show.
  function automatic image_words_t apply_update(input lcd_update_t u);
    image_words_t img;
    int           v;
    int unsigned  n;
    bit           neg;
    bit           point;
    v = u.value;
    case (u.func)
      FN_TOP: begin
        lcd_model[0 +: 8]   = '0;
        lcd_model[8]        = 1'b0;
        lcd_model[16 +: 24] = '0;
        lcd_model[44 +: 4]  = '0;
        lcd_model[136 +: 4] = '0;
        if (v > TOP_HI_LIMIT) begin
          lcd_model[16 +: 8] |= 8'hF5;
          lcd_model[24 +: 8] |= 8'h7B;
          lcd_model[32 +: 8] |= 8'h10;
        end else if (v < LOW_LIMIT) begin
          lcd_model[16 +: 8] |= 8'hF3;
          lcd_model[24 +: 8] |= 8'h13;
          lcd_model[32 +: 8] |= 8'h77;
        end else begin
          n = shown_magnitude(v, TOP_POINT_LIMIT, neg, point);
          if (point) lcd_model[44] = 1'b1;
          if (neg) lcd_model[18] = 1'b1;
          // The leading "1" covers values up to 1999 whole units.
          if (n > 999) lcd_model[8] = 1'b1;
          if (n > 99) light_digit(n / 100 % 10, SLOT_TOP_L);
          light_digit((n > 9) ? n / 10 % 10 : 0, SLOT_TOP_M);
          light_digit(n % 10, SLOT_TOP_R);
        end
      end
      FN_BOT: begin
        lcd_model[40 +: 4]  = '0;
        lcd_model[48 +: 32] = '0;
        lcd_model[84 +: 4]  = '0;
        lcd_model[143]      = 1'b0;
        // The percent sign is drawn even over the Hi and Lo patterns.
        if (u.pct) lcd_model[65] = 1'b1;
        if (v > BOT_HI_LIMIT) begin
          lcd_model[40 +: 4] = 4'hF;
          lcd_model[48 +: 8] |= 8'h57;
          lcd_model[56 +: 8] |= 8'hB1;
        end else if (v < LOW_LIMIT) begin
          lcd_model[40 +: 4] = 4'hF;
          lcd_model[48 +: 8] |= 8'h31;
          lcd_model[56 +: 8] |= 8'h37;
          lcd_model[64 +: 8] |= 8'h70;
        end else begin
          n = shown_magnitude(v, BOT_POINT_LIMIT, neg, point);
          if (point) lcd_model[64] = 1'b1;
          if (neg) lcd_model[54] = 1'b1;
          if (n > 99) light_digit(n / 100 % 10, SLOT_BOT_L);
          light_digit((n > 9) ? n / 10 % 10 : 0, SLOT_BOT_M);
          light_digit(n % 10, SLOT_BOT_R);
        end
      end
      // Degree lands on bit 6, dash on bit 5, underscore on bit 4 of the last byte.
      FN_SYM: lcd_model[140 +: 3] = {u.sym[0], u.sym[1], u.sym[2]};
      FN_BATT: begin
        lcd_model[8 +: 8] &= ~8'hEE;
        if (u.en) begin
          lcd_model[13] = 1'b1;
          if (u.lvl >= 7'd16) lcd_model[9]  = 1'b1;
          if (u.lvl >= 7'd33) lcd_model[10] = 1'b1;
          if (u.lvl >= 7'd49) lcd_model[11] = 1'b1;
          if (u.lvl >= 7'd67) lcd_model[15] = 1'b1;
          if (u.lvl >= 7'd83) lcd_model[14] = 1'b1;
        end
      end
      FN_LINK: lcd_model[12] = u.en;
      default: ;
    endcase
    img.low  = lcd_model[63:0];
    img.mid  = lcd_model[127:64];
    img.high = lcd_model[143:128];
    return img;
  endfunction

  function automatic void queue_update(input logic [2:0] f, input int v, input logic p,
                                       input logic [2:0] sy, input logic e,
                                       input logic [6:0] lv, input bit drain);
    lcd_update_t u;
    u.func  = f;
    u.value = v[15:0];
    u.pct   = p;
    u.sym   = sy;
    u.en    = e;
    u.lvl   = lv;
    u.gap   = tx_quiet ? 0 : $urandom_range(0, 15);
    u.drain = drain;
    pending_updates.push_back(u);
  endfunction

  // Sender: presents queued updates, idling between them, and predicts each accepted one.
  always @(posedge clk) begin : driver
    lcd_update_t nxt;
    if (rst) begin
      s_tvalid  <= 1'b0;
      idle_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_images.push_back(apply_update(on_bus));
        func_hits[on_bus.func]++;
        updates_done++;
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          s_tvalid  <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_updates.size() != 0 &&
                     !(pending_updates[0].drain && expected_images.size() != 0)) begin
          nxt = pending_updates.pop_front();
          on_bus    <= nxt;
          s_tuser   <= nxt.func;
          s_tdata   <= {4'b0000, nxt.lvl, nxt.en, nxt.sym, nxt.pct, nxt.value};
          s_tvalid  <= 1'b1;
          idle_left <= nxt.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every image transaction against the oldest prediction and stalls
  // for a random number of cycles after each one, with occasional stall-free stretches.
  always @(posedge clk) begin : monitor
    image_words_t want;
    int           hold;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_images.size() == 0) begin
        report_mismatch("unexpected image", m_tdata[63:0], '0);
      end else begin
        want = expected_images.pop_front();
        if (m_tdata[63:0] !== want.low) report_mismatch("image_low", m_tdata[63:0], want.low);
        if (m_tdata[127:64] !== want.mid)
          report_mismatch("image_mid", m_tdata[127:64], want.mid);
        if (m_tdata[143:128] !== want.high)
          report_mismatch("image_high", {48'd0, m_tdata[143:128]}, {48'd0, want.high});
      end
      images_checked++;
      if (images_checked % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      hold = rx_quiet ? 0 : $urandom_range(0, 15);
      if (hold == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready   <= 1'b0;
        stall_left <= hold - 1;
      end
    end else if (!m_tready) begin
      if (stall_left == 0) m_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  initial begin : stimulus
    int          i;
    int          v;
    int          pick;
    logic [2:0]  f;
    logic [6:0]  lv;
    bit          drain;

    // Directed part: the Hi and Lo limits, the point limits, rounding, the leading one,
    // the 16-bit extremes, the symbols, full, low and disabled battery bars, the link icon, spare codes.
    queue_update(FN_TOP, 19996, 1'b1, 3'd7, 1'b1, 7'd127, 1'b0);
    queue_update(FN_TOP, -996, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, 1995, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, 1996, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, -96, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, 32767, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, -32768, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, 9999, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_TOP, 7, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BOT, 9996, 1'b1, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BOT, -996, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BOT, 995, 1'b1, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BOT, -95, 1'b1, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BOT, 996, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_SYM, 0, 1'b0, 3'd7, 1'b0, 7'd0, 1'b0);
    queue_update(FN_SYM, 0, 1'b0, 3'd2, 1'b0, 7'd0, 1'b0);
    queue_update(FN_BATT, 0, 1'b0, 3'd0, 1'b1, 7'd127, 1'b0);
    queue_update(FN_BATT, 0, 1'b0, 3'd0, 1'b1, 7'd15, 1'b0);
    queue_update(FN_BATT, 0, 1'b0, 3'd0, 1'b0, 7'd100, 1'b0);
    queue_update(FN_LINK, 0, 1'b0, 3'd0, 1'b1, 7'd0, 1'b0);
    queue_update(FN_LINK, 0, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);
    queue_update(FN_SPARE_FIRST, -1, 1'b1, 3'd7, 1'b1, 7'd127, 1'b0);
    queue_update(FN_SPARE_LAST, 0, 1'b0, 3'd0, 1'b0, 7'd0, 1'b0);

    // Random part: mostly number updates, with values spread over the displayable range,
    // around every limit, and over the whole 16-bit field.
    for (i = 0; i < 450; i++) begin
      if (i % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) f = FN_TOP;
      else if (pick < 60) f = FN_BOT;
      else if (pick < 70) f = FN_SYM;
      else if (pick < 82) f = FN_BATT;
      else if (pick < 90) f = FN_LINK;
      else f = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 65535);
        1: v = int'($urandom_range(0, 21200)) - 1200;
        2: v = int'($urandom_range(0, 2200)) - 200;
        3: begin
          case ($urandom_range(0, 6))
            0: v = TOP_HI_LIMIT;
            1: v = BOT_HI_LIMIT;
            2: v = LOW_LIMIT;
            3: v = TOP_POINT_LIMIT;
            4: v = BOT_POINT_LIMIT;
            5: v = POINT_LOW_LIMIT;
            default: v = 9990;
          endcase
          v = v + int'($urandom_range(0, 6)) - 3;
        end
        default: v = int'($urandom_range(0, 11000)) - 1100;
      endcase
      lv = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, 100));
      drain = (i == 120 || i == 320 || $urandom_range(0, 99) == 0);
      queue_update(f, v, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)), lv, drain);
    end
    total_updates = pending_updates.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (updates_done < total_updates) @(posedge clk);
    while (expected_images.size() != 0) @(posedge clk);
    // Anything that shows up now has no prediction behind it.
    repeat (30) @(posedge clk);

    $display("Sent %0d updates: top %0d, bottom %0d, symbol %0d, battery %0d, link %0d,",
             updates_done, func_hits[FN_TOP], func_hits[FN_BOT], func_hits[FN_SYM],
             func_hits[FN_BATT], func_hits[FN_LINK]);
    $display("spare codes %0d; %0d images compared, %0d mismatches.",
             updates_done - func_hits[FN_TOP] - func_hits[FN_BOT] - func_hits[FN_SYM]
             - func_hits[FN_BATT] - func_hits[FN_LINK], images_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a millisecond.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d updates sent and %0d images outstanding.",
             updates_done, expected_images.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/slcd_pkg.sv
rtl/slcd_scale.sv
rtl/slcd_digits.sv
rtl/slcd_paint.sv
rtl/segment_lcd_number_formatter.sv
dv/testbench.sv
